// ----- rtl/core/bmc_pkg.sv -----
// Types, codes and lookup functions shared by the message checker modules.
// No dependencies.
`default_nettype none
package bmc_pkg;

   localparam int MAX_MESSAGE_BYTES_DEF = 4096;
   localparam int POS_W = 18;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       first_byte;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      logic [2:0] status;
      logic [7:0] error_code;
      logic [7:0] suberror_code;
      logic [4:0] detail;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_NONE      = 3'd0,
      ST_OPEN_WALK = 3'd1,
      ST_UPD_PLEN  = 3'd2,
      ST_UPD_WALK  = 3'd3,
      ST_STOP      = 3'd7
   } stage_type;

   localparam logic [3:0] FS_HEAD0 = 4'd0;
   localparam logic [3:0] FS_HEAD1 = 4'd1;
   localparam logic [3:0] FS_HEAD2 = 4'd2;
   localparam logic [3:0] FS_HEAD3 = 4'd3;
   localparam logic [3:0] FS_DATA  = 4'd15;

   localparam logic [1:0] SS_CODE = 2'd0;
   localparam logic [1:0] SS_LEN  = 2'd1;
   localparam logic [1:0] SS_BODY = 2'd2;

   localparam logic [2:0] STS_VALID      = 3'd0;
   localparam logic [2:0] STS_VALID_AS4  = 3'd1;
   localparam logic [2:0] STS_INVALID    = 3'd2;
   localparam logic [2:0] STS_INCOMPLETE = 3'd3;
   localparam logic [2:0] STS_NOTIFY     = 3'd4;

   localparam logic [7:0] KIND_OPEN   = 8'd1;
   localparam logic [7:0] KIND_UPDATE = 8'd2;
   localparam logic [7:0] KIND_NOTIFY = 8'd3;
   localparam logic [7:0] KIND_KEEP   = 8'd4;

   localparam logic [4:0] DT_NONE       = 5'd0;
   localparam logic [4:0] DT_MARKER     = 5'd1;
   localparam logic [4:0] DT_TYPE       = 5'd2;
   localparam logic [4:0] DT_LENGTH     = 5'd3;
   localparam logic [4:0] DT_NOTE_SHORT = 5'd4;
   localparam logic [4:0] DT_VERSION    = 5'd5;
   localparam logic [4:0] DT_HOLD       = 5'd6;
   localparam logic [4:0] DT_OPT_LEN    = 5'd7;
   localparam logic [4:0] DT_OPT_PARAM  = 5'd8;
   localparam logic [4:0] DT_CAP_WALK   = 5'd9;
   localparam logic [4:0] DT_CAP_LEN    = 5'd10;
   localparam logic [4:0] DT_NO_V6      = 5'd11;
   localparam logic [4:0] DT_UPD_LEN    = 5'd12;
   localparam logic [4:0] DT_ATTR_WALK  = 5'd13;
   localparam logic [4:0] DT_AS_PATH    = 5'd14;
   localparam logic [4:0] DT_NEXT_HOP   = 5'd15;
   localparam logic [4:0] DT_MP_NLRI    = 5'd16;

   typedef struct packed {
      logic [15:0]      pos;
      logic [15:0]      mlen;
      logic [7:0]       kind;
      logic             marker_good;
      logic             verdict_given;
      logic [POS_W-1:0] region_end;
      logic [POS_W-1:0] element_end;
      logic [POS_W-1:0] inner_end;
      logic [3:0]       field_step;
      logic [15:0]      field_value;
      logic [4:0]       pending;
      logic             total_mismatch;
      logic             saw_v6;
      logic             saw_as4;
      stage_type        stage;
      logic [7:0]       elem_type;
      logic [7:0]       elem_flags;
      logic [15:0]      elem_len;
      logic [1:0]       sub_step;
      logic [7:0]       sub_code;
      logic [7:0]       sub_len;
      logic [2:0]       sub_count;
      logic [15:0]      sub_value;
      logic [4:0]       param_pending;
      logic             sub_bad;
      logic             mp_active;
   } state_type;

   typedef struct packed {
      logic blocked;
      logic fire;
   } flow_type;

   function automatic logic [7:0] err_of(input logic [4:0] d);
      logic [7:0] r;
      unique case (d)
         DT_MARKER, DT_TYPE, DT_LENGTH: r = 8'd1;
         DT_VERSION, DT_HOLD, DT_OPT_LEN, DT_OPT_PARAM,
         DT_CAP_WALK, DT_CAP_LEN, DT_NO_V6: r = 8'd2;
         DT_UPD_LEN, DT_ATTR_WALK, DT_AS_PATH, DT_NEXT_HOP, DT_MP_NLRI: r = 8'd3;
         default: r = 8'd0;
      endcase
      return r;
   endfunction

   function automatic logic [7:0] sub_of(input logic [4:0] d);
      logic [7:0] r;
      unique case (d)
         DT_MARKER:    r = 8'd1;
         DT_TYPE:      r = 8'd3;
         DT_LENGTH:    r = 8'd2;
         DT_VERSION:   r = 8'd1;
         DT_HOLD:      r = 8'd6;
         DT_OPT_PARAM: r = 8'd4;
         DT_ATTR_WALK: r = 8'd1;
         DT_AS_PATH:   r = 8'd11;
         default:      r = 8'd0;
      endcase
      return r;
   endfunction

endpackage
`default_nettype wire

// ----- rtl/core/bmc_in_stage.sv -----
// Input register for request beats.
// Depends on bmc_pkg.
`default_nettype none
module bmc_in_stage
   import bmc_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_payload,
   input  wire flow_type flow,
   output logic         in_valid,
   output req_type      in_beat
);
   logic    valid_ff, valid_in;
   req_type beat_ff;

   assign req_stall = valid_ff & flow.blocked;
   assign valid_in  = req_stall ? valid_ff : req_valid;
   assign in_valid  = valid_ff;
   assign in_beat   = beat_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall) begin
         beat_ff <= req_payload;
      end
   end
endmodule
`default_nettype wire

// ----- rtl/core/bmc_core.sv -----
// Per-byte message state and verdict logic.
// Depends on bmc_pkg.
`default_nettype none
module bmc_core
   import bmc_pkg::*;
#(
   parameter int MAX_MESSAGE_BYTES = MAX_MESSAGE_BYTES_DEF
)
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire flow_type flow,
   input  wire req_type  in_beat,
   output logic          res_valid,
   output rsp_type       res
);
   localparam logic [16:0] MAX_LEN = 17'(MAX_MESSAGE_BYTES);

   state_type st_ff, st_in;
   state_type rst_state;

   always_comb begin
      rst_state = '0;
      rst_state.marker_good = 1'b1;
      rst_state.verdict_given = 1'b1;
   end

   always_comb begin
      state_type n;
      logic [7:0] b;
      logic [POS_W-1:0] p, p1, w18;
      logic [15:0] len16, wv;
      logic [4:0] d;
      logic emitted, do_hdr;
      emitted = 1'b0;
      do_hdr = 1'b0;
      res = '0;
      n = st_ff;
      b = in_beat.data_byte;
      p = '0;
      p1 = '0;
      w18 = '0;
      len16 = '0;
      wv = '0;
      d = DT_NONE;
      if (in_beat.first_byte || !st_ff.verdict_given) begin
         if (in_beat.first_byte) begin
            n = '0;
            n.marker_good = 1'b1;
            n.stage = ST_NONE;
         end
         p = POS_W'(n.pos);
         p1 = p + 1'b1;
         n.pos = n.pos + 1'b1;
         if (p < 16) begin
            if (b != 8'hFF) n.marker_good = 1'b0;
         end else if (p == 16) begin
            n.mlen = {b, 8'h00};
         end else if (p == 17) begin
            n.mlen[7:0] = b;
         end else if (p == 18) begin
            n.kind = b;
            if (b == KIND_NOTIFY) begin
               if (n.mlen < 16'd21) begin
                  emitted = 1'b1;
                  res = '{STS_NOTIFY, 8'd0, 8'd0, DT_NOTE_SHORT};
               end
            end else if (!n.marker_good) begin
               emitted = 1'b1;
               res = '{STS_INVALID, 8'd1, 8'd1, DT_MARKER};
            end else if (b == 8'd0 || b > KIND_KEEP) begin
               emitted = 1'b1;
               res = '{STS_INVALID, 8'd1, 8'd3, DT_TYPE};
            end else if (n.mlen < 16'd19 || {1'b0, n.mlen} > MAX_LEN ||
                         (b == KIND_OPEN && n.mlen < 16'd29) ||
                         (b == KIND_UPDATE && n.mlen < 16'd23) ||
                         (b == KIND_KEEP && n.mlen != 16'd19)) begin
               emitted = 1'b1;
               res = '{STS_INVALID, 8'd1, 8'd2, DT_LENGTH};
            end else if (n.mlen == 16'd19) begin
               emitted = 1'b1;
               res = '{STS_VALID, 8'd0, 8'd0, DT_NONE};
            end
         end else if (n.kind == KIND_NOTIFY) begin
            if (p == 19) begin
               n.field_value = {8'd0, b};
            end else if (p == 20) begin
               emitted = 1'b1;
               res = '{STS_NOTIFY, n.field_value[7:0], b, DT_NONE};
            end
         end else begin
            if (n.kind == KIND_OPEN) begin
               if (p == 19) begin
                  if (b != 8'd4 && n.pending == 0) n.pending = DT_VERSION;
               end else if (p == 22) begin
                  n.field_value = {8'd0, b};
               end else if (p == 23) begin
                  if ({n.field_value[7:0], b} <= 16'd2 && n.pending == 0)
                     n.pending = DT_HOLD;
               end else if (p == 28) begin
                  if (17'd29 + 17'(b) != {1'b0, n.mlen}) begin
                     if (n.pending == 0) n.pending = DT_OPT_LEN;
                  end else if (n.pending == 0) begin
                     n.stage = ST_OPEN_WALK;
                     n.region_end = POS_W'(n.mlen);
                     n.element_end = POS_W'(29);
                     n.field_step = FS_HEAD0;
                  end
               end else if (p >= 29 && n.stage == ST_OPEN_WALK) begin
                  if (n.field_step == FS_HEAD0 && p + 2'd2 > n.region_end) begin
                     n.total_mismatch = 1'b1;
                     n.stage = ST_STOP;
                  end else begin
                     if (n.field_step == FS_HEAD0) begin
                        n.elem_type = b;
                        if (b != 8'd2 && n.pending == 0) n.pending = DT_OPT_PARAM;
                        n.field_step = FS_HEAD1;
                     end else if (n.field_step == FS_HEAD1) begin
                        n.element_end = p1 + POS_W'(b);
                        n.inner_end = p1;
                        n.sub_step = SS_CODE;
                        n.sub_bad = 1'b0;
                        n.param_pending = DT_NONE;
                        if (b == 0) begin
                           if (n.inner_end != n.element_end) begin
                              if (n.pending == 0) n.pending = DT_CAP_WALK;
                           end
                           n.field_step = FS_HEAD0;
                        end else begin
                           n.field_step = FS_DATA;
                        end
                     end else begin
                        if (!n.sub_bad) begin
                           if (n.sub_step == SS_CODE) begin
                              if (p == n.inner_end) begin
                                 if (p + 2'd2 > n.element_end) begin
                                    n.sub_bad = 1'b1;
                                 end else begin
                                    n.sub_code = b;
                                    n.sub_step = SS_LEN;
                                 end
                              end
                           end else if (n.sub_step == SS_LEN) begin
                              n.sub_len = b;
                              n.inner_end = p1 + POS_W'(b);
                              n.sub_count = 3'd0;
                              if ((n.sub_code == 8'd65 || n.sub_code == 8'd1) &&
                                  b != 8'd4 && n.param_pending == 0)
                                 n.param_pending = DT_CAP_LEN;
                              if (n.sub_code == 8'd65 && b == 8'd4) n.saw_as4 = 1'b1;
                              n.sub_step = (b != 0) ? SS_BODY : SS_CODE;
                           end else begin
                              if (n.sub_code == 8'd1 && n.sub_len == 8'd4) begin
                                 if (n.sub_count == 3'd0) n.sub_value = {8'd0, b};
                                 else if (n.sub_count == 3'd1)
                                    n.sub_value = {n.sub_value[7:0], b};
                                 else if (n.sub_count == 3'd3 && n.sub_value == 16'd2 &&
                                          b == 8'd1)
                                    n.saw_v6 = 1'b1;
                              end
                              if (n.sub_count != 3'd7) n.sub_count = n.sub_count + 1'b1;
                              if (p1 == n.inner_end) n.sub_step = SS_CODE;
                           end
                        end
                        if (p1 == n.element_end) begin
                           if (n.sub_bad || n.inner_end != n.element_end) begin
                              if (n.pending == 0) n.pending = DT_CAP_WALK;
                           end else if (n.param_pending != 0 && n.pending == 0) begin
                              n.pending = n.param_pending;
                           end
                           n.field_step = FS_HEAD0;
                        end
                     end
                     if (p1 == n.region_end) begin
                        if (n.field_step != FS_HEAD0 || n.element_end != n.region_end)
                           n.total_mismatch = 1'b1;
                        n.stage = ST_STOP;
                     end
                  end
               end
            end else if (n.kind == KIND_UPDATE) begin
               if (p == 19) begin
                  n.field_value = {8'd0, b};
               end else if (p == 20) begin
                  wv = {n.field_value[7:0], b};
                  if (POS_W'(23) + POS_W'(wv) > POS_W'(n.mlen)) begin
                     if (n.pending == 0) n.pending = DT_UPD_LEN;
                     n.stage = ST_STOP;
                  end else begin
                     n.region_end = POS_W'(21) + POS_W'(wv);
                     n.stage = ST_UPD_PLEN;
                  end
               end else if (n.stage == ST_UPD_PLEN) begin
                  if (p == n.region_end) begin
                     n.field_value = {8'd0, b};
                  end else if (p == n.region_end + 1'b1) begin
                     wv = {n.field_value[7:0], b};
                     if (p1 + POS_W'(wv) > POS_W'(n.mlen)) begin
                        if (n.pending == 0) n.pending = DT_UPD_LEN;
                        n.stage = ST_STOP;
                     end else if (wv == 0) begin
                        n.stage = ST_STOP;
                     end else begin
                        n.element_end = p1;
                        n.region_end = p1 + POS_W'(wv);
                        n.field_step = FS_HEAD0;
                        n.stage = ST_UPD_WALK;
                     end
                  end
               end else if (n.stage == ST_UPD_WALK) begin
                  if (n.field_step == FS_HEAD0 && p + 2'd3 > n.region_end) begin
                     n.total_mismatch = 1'b1;
                     n.stage = ST_STOP;
                  end else begin
                     if (n.field_step == FS_HEAD0) begin
                        n.elem_flags = b;
                        n.field_step = FS_HEAD1;
                     end else if (n.field_step == FS_HEAD1) begin
                        n.elem_type = b;
                        n.field_step = FS_HEAD2;
                     end else if (n.field_step == FS_HEAD2) begin
                        if (n.elem_flags[4]) begin
                           n.field_value = {8'd0, b};
                           n.field_step = FS_HEAD3;
                        end else begin
                           do_hdr = 1'b1;
                           len16 = {8'd0, b};
                        end
                     end else if (n.field_step == FS_HEAD3) begin
                        do_hdr = 1'b1;
                        len16 = {n.field_value[7:0], b};
                     end else begin
                        if (n.mp_active) begin
                           if (n.sub_step == SS_LEN) begin
                              if (p == n.inner_end)
                                 n.inner_end = p1 + POS_W'((9'(b) + 9'd7) >> 3);
                           end else if (n.sub_count == 3'd0) begin
                              n.sub_value = {8'd0, b};
                           end else if (n.sub_count == 3'd1) begin
                              n.sub_value = {n.sub_value[7:0], b};
                           end else if (n.sub_count == 3'd2) begin
                              if (!(n.sub_value == 16'd2 && b == 8'd1)) begin
                                 n.mp_active = 1'b0;
                              end else if (n.elem_type == 8'd15) begin
                                 n.inner_end = p1;
                                 n.sub_step = SS_LEN;
                              end
                           end else if (n.sub_count == 3'd3) begin
                              if (b != 8'd16 && b != 8'd32) begin
                                 if (n.pending == 0) n.pending = DT_NEXT_HOP;
                                 n.mp_active = 1'b0;
                              end else if (17'(n.elem_len) < 17'd5 + 17'(b)) begin
                                 if (n.pending == 0) n.pending = DT_MP_NLRI;
                                 n.mp_active = 1'b0;
                              end else begin
                                 n.inner_end = p + 2'd2 + POS_W'(b);
                                 n.sub_step = SS_LEN;
                              end
                           end
                           if (n.sub_count != 3'd7) n.sub_count = n.sub_count + 1'b1;
                        end
                        if (p1 == n.element_end) begin
                           if (n.mp_active &&
                               (n.sub_step != SS_LEN || n.inner_end != n.element_end)) begin
                              if (n.pending == 0) n.pending = DT_MP_NLRI;
                           end
                           n.field_step = FS_HEAD0;
                        end
                     end
                     if (do_hdr) begin
                        n.elem_len = len16;
                        n.element_end = p1 + POS_W'(len16);
                        n.mp_active = 1'b0;
                        n.sub_count = 3'd0;
                        n.sub_step = SS_CODE;
                        n.sub_value = 16'd0;
                        if (n.elem_type == 8'd2 && len16 < 16'd2 && n.pending == 0)
                           n.pending = DT_AS_PATH;
                        if (n.elem_type == 8'd14 || n.elem_type == 8'd15) begin
                           if (len16 < 16'd3) begin
                              if (n.pending == 0) n.pending = DT_MP_NLRI;
                           end else begin
                              n.mp_active = 1'b1;
                           end
                        end
                        n.field_step = (len16 != 0) ? FS_DATA : FS_HEAD0;
                     end
                     if (p1 == n.region_end) begin
                        if (n.field_step != FS_HEAD0 || n.element_end != n.region_end)
                           n.total_mismatch = 1'b1;
                        n.stage = ST_STOP;
                     end
                  end
               end
            end
            w18 = POS_W'(n.mlen);
            if (p1 == w18) begin
               emitted = 1'b1;
               if (n.total_mismatch) begin
                  d = (n.kind == KIND_OPEN) ? DT_OPT_LEN : DT_ATTR_WALK;
               end else if (n.pending != 0) begin
                  d = n.pending;
               end else if (n.kind == KIND_OPEN && !n.saw_v6) begin
                  d = DT_NO_V6;
               end
               if (d != DT_NONE) begin
                  res = '{STS_INVALID, err_of(d), sub_of(d), d};
               end else begin
                  res = '{(n.kind == KIND_OPEN && n.saw_as4) ? STS_VALID_AS4 : STS_VALID,
                          8'd0, 8'd0, DT_NONE};
               end
            end
         end
         if (!emitted && in_beat.last_byte) begin
            emitted = 1'b1;
            res = '{STS_INCOMPLETE, 8'd0, 8'd0, DT_NONE};
         end
         if (emitted) n.verdict_given = 1'b1;
      end
      st_in = n;
      res_valid = emitted;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= rst_state;
      end else if (flow.fire) begin
         st_ff <= st_in;
      end
   end
endmodule
`default_nettype wire

// ----- rtl/core/bmc_out_stage.sv -----
// Result register for response beats.
// Depends on bmc_pkg.
`default_nettype none
module bmc_out_stage
   import bmc_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    in_valid,
   input  wire logic    res_valid,
   input  wire rsp_type res,
   output flow_type     flow,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_payload
);
   logic    valid_ff, valid_in;
   rsp_type data_ff;

   assign flow.blocked = valid_ff & rsp_stall & res_valid;
   assign flow.fire    = in_valid & ~flow.blocked;
   assign valid_in     = (flow.fire & res_valid) ? 1'b1 : (rsp_stall & valid_ff);
   assign rsp_valid    = valid_ff;
   assign rsp_payload  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (flow.fire & res_valid) begin
         data_ff <= res;
      end
   end
endmodule
`default_nettype wire

// ----- rtl/core/bgp_message_checker_unit.sv -----
// BGP-4 message checker: one byte beat in, at most one verdict beat out.
// The verdict beat for an accepted byte passes through the input register and then the result register.
// Throughput: one byte per cycle; only a byte that yields a verdict holds while an earlier verdict waits.
// Reset (synchronous): no beats held, checker idle until a first byte arrives.
// Depends on bmc_pkg, bmc_in_stage, bmc_core, bmc_out_stage.
`default_nettype none
module bgp_message_checker_unit
   import bmc_pkg::*;
#(
   parameter int MAX_MESSAGE_BYTES = MAX_MESSAGE_BYTES_DEF
)
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_payload,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_payload
);
   flow_type flow;
   logic     in_valid, res_valid;
   req_type  in_beat;
   rsp_type  res;

   bmc_in_stage u_in (
      .clock, .reset, .req_valid, .req_stall, .req_payload,
      .flow, .in_valid, .in_beat
   );

   bmc_core #(.MAX_MESSAGE_BYTES(MAX_MESSAGE_BYTES)) u_core (
      .clock, .reset, .flow, .in_beat, .res_valid, .res
   );

   bmc_out_stage u_out (
      .clock, .reset, .in_valid, .res_valid, .res, .flow,
      .rsp_valid, .rsp_stall, .rsp_payload
   );
endmodule
`default_nettype wire

// ----- test/tb.sv -----
// Self-checking bench for bgp_message_checker_unit: directed message table, then random
// OPEN/UPDATE/NOTIFICATION/KEEPALIVE traffic with corruption, checked by a byte-level predictor.
// Depends on bmc_pkg and the checker RTL.
module tb;
   import bmc_pkg::*;

   localparam int MSG_MAX = MAX_MESSAGE_BYTES_DEF;
   localparam int STALL_LIMIT = 4000;
   localparam int RANDOM_BYTES = 2000;
   localparam int RANDOM_VERDICTS = 60;
   localparam logic [1:0] SS_PREFIX = SS_LEN;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_payload;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_payload;

   bgp_message_checker_unit uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_payload(rsp_payload)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // predictor state
   int unsigned pos, mlen, kind, region_end, element_end, inner_end;
   int unsigned fstep, fval, pend, etype, eflags, elen;
   int unsigned sstep, scode, slen, scount, sval, ppend;
   bit          mgood, vgiven, tmis, saw_v6, saw_as4, sbad, mp_on;
   stage_type   stg;

   logic [7:0] err_tab [17] = '{0, 1, 1, 1, 0, 2, 2, 2, 2, 2, 2, 2, 3, 3, 3, 3, 3};
   logic [7:0] sub_tab [17] = '{0, 1, 3, 2, 0, 1, 6, 0, 4, 0, 0, 0, 0, 1, 11, 0, 0};

   rsp_type    verdicts [$];
   logic [7:0] pkt [$];
   int         errors, bytes_sent, verdicts_seen, verdicts_made, idle_beats;
   int         status_cnt [8];
   int         hold_left;
   bit         idle_on;
   bit         pred_seen;
   rsp_type    last_pred;

   function automatic void clear_msg();
      pos = 0; mlen = 0; kind = 0; mgood = 1; vgiven = 0;
      region_end = 0; element_end = 0; inner_end = 0; fstep = FS_HEAD0; fval = 0;
      pend = 0; tmis = 0; saw_v6 = 0; saw_as4 = 0; stg = ST_NONE;
      etype = 0; eflags = 0; elen = 0; sstep = SS_CODE; scode = 0; slen = 0;
      scount = 0; sval = 0; ppend = 0; sbad = 0; mp_on = 0;
   endfunction

   function automatic void note(int unsigned r);
      if (pend == 0) pend = r;
   endfunction

   function automatic rsp_type mk(logic [2:0] st, logic [7:0] e, logic [7:0] s,
                                  logic [4:0] d);
      rsp_type o;
      o.status = st; o.error_code = e; o.suberror_code = s; o.detail = d;
      return o;
   endfunction

   function automatic void cap_byte(int unsigned b, int unsigned p);
      if (sbad) return;
      if (sstep == SS_CODE) begin
         if (p != inner_end) return;
         if (p + 2 > element_end) begin
            sbad = 1;
            return;
         end
         scode = b; sstep = SS_LEN;
      end else if (sstep == SS_LEN) begin
         slen = b; inner_end = p + 1 + b; scount = 0;
         if ((scode == 65 || scode == 1) && b != 4 && ppend == 0) ppend = DT_CAP_LEN;
         if (scode == 65 && b == 4) saw_as4 = 1;
         sstep = b ? SS_BODY : SS_CODE;
      end else begin
         if (scode == 1 && slen == 4) begin
            if (scount == 0) sval = b;
            else if (scount == 1) sval = ((sval << 8) | b) & 16'hFFFF;
            else if (scount == 3 && sval == 2 && b == 1) saw_v6 = 1;
         end
         scount++;
         if (p + 1 == inner_end) sstep = SS_CODE;
      end
   endfunction

   function automatic void param_done();
      if (sbad || inner_end != element_end) note(DT_CAP_WALK);
      else if (ppend) note(ppend);
   endfunction

   function automatic void open_walk(int unsigned b, int unsigned p);
      if (fstep == FS_HEAD0) begin
         if (p + 2 > region_end) begin
            tmis = 1; stg = ST_STOP;
            return;
         end
         etype = b;
         if (b != 2) note(DT_OPT_PARAM);
         fstep = FS_HEAD1;
      end else if (fstep == FS_HEAD1) begin
         element_end = p + 1 + b; inner_end = p + 1;
         sstep = SS_CODE; sbad = 0; ppend = 0;
         if (b == 0) begin
            param_done(); fstep = FS_HEAD0;
         end else fstep = FS_DATA;
      end else begin
         cap_byte(b, p);
         if (p + 1 == element_end) begin
            param_done(); fstep = FS_HEAD0;
         end
      end
      if (p + 1 == region_end) begin
         if (fstep != FS_HEAD0 || element_end != region_end) tmis = 1;
         stg = ST_STOP;
      end
   endfunction

   function automatic void attr_head(int unsigned len, int unsigned p);
      elen = len; element_end = p + 1 + len;
      mp_on = 0; scount = 0; sstep = SS_CODE; sval = 0;
      if (etype == 2 && len < 2) note(DT_AS_PATH);
      if (etype == 14 || etype == 15) begin
         if (len < 3) note(DT_MP_NLRI);
         else mp_on = 1;
      end
      fstep = len ? FS_DATA : FS_HEAD0;
   endfunction

   function automatic void attr_body(int unsigned b, int unsigned p);
      if (!mp_on) return;
      if (sstep == SS_PREFIX) begin
         if (p == inner_end) inner_end = p + 1 + (b + 7) / 8;
      end else if (scount == 0) sval = b;
      else if (scount == 1) sval = ((sval << 8) | b) & 16'hFFFF;
      else if (scount == 2) begin
         if (!(sval == 2 && b == 1)) mp_on = 0;
         else if (etype == 15) begin
            inner_end = p + 1; sstep = SS_PREFIX;
         end
      end else if (scount == 3) begin
         if (b != 16 && b != 32) begin
            note(DT_NEXT_HOP); mp_on = 0;
         end else if (elen < 5 + b) begin
            note(DT_MP_NLRI); mp_on = 0;
         end else begin
            inner_end = p + 2 + b; sstep = SS_PREFIX;
         end
      end
      scount++;
   endfunction

   function automatic void attr_walk(int unsigned b, int unsigned p);
      if (fstep == FS_HEAD0) begin
         if (p + 3 > region_end) begin
            tmis = 1; stg = ST_STOP;
            return;
         end
         eflags = b; fstep = FS_HEAD1;
      end else if (fstep == FS_HEAD1) begin
         etype = b; fstep = FS_HEAD2;
      end else if (fstep == FS_HEAD2) begin
         if (eflags & 8'h10) begin
            fval = b; fstep = FS_HEAD3;
         end else attr_head(b, p);
      end else if (fstep == FS_HEAD3) begin
         attr_head(((fval << 8) | b) & 16'hFFFF, p);
      end else begin
         attr_body(b, p);
         if (p + 1 == element_end) begin
            if (mp_on && (sstep != SS_PREFIX || inner_end != element_end)) note(DT_MP_NLRI);
            fstep = FS_HEAD0;
         end
      end
      if (p + 1 == region_end) begin
         if (fstep != FS_HEAD0 || element_end != region_end) tmis = 1;
         stg = ST_STOP;
      end
   endfunction

   function automatic void open_byte(int unsigned b, int unsigned p);
      if (p == 19) begin
         if (b != 4) note(DT_VERSION);
      end else if (p == 22) fval = b;
      else if (p == 23) begin
         if ((((fval << 8) | b) & 16'hFFFF) <= 2) note(DT_HOLD);
      end else if (p == 28) begin
         if (29 + b != mlen) note(DT_OPT_LEN);
         else if (pend == 0) begin
            stg = ST_OPEN_WALK; region_end = mlen; element_end = 29; fstep = FS_HEAD0;
         end
      end else if (p >= 29 && stg == ST_OPEN_WALK) open_walk(b, p);
   endfunction

   function automatic void update_byte(int unsigned b, int unsigned p);
      int unsigned w;
      if (p == 19) fval = b;
      else if (p == 20) begin
         w = ((fval << 8) | b) & 16'hFFFF;
         if (23 + w > mlen) begin
            note(DT_UPD_LEN); stg = ST_STOP;
         end else begin
            region_end = 21 + w; stg = ST_UPD_PLEN;
         end
      end else if (stg == ST_UPD_PLEN) begin
         if (p == region_end) fval = b;
         else if (p == region_end + 1) begin
            w = ((fval << 8) | b) & 16'hFFFF;
            if (p + 1 + w > mlen) begin
               note(DT_UPD_LEN); stg = ST_STOP;
            end else if (w == 0) stg = ST_STOP;
            else begin
               element_end = p + 1; region_end = p + 1 + w; fstep = FS_HEAD0;
               stg = ST_UPD_WALK;
            end
         end
      end else if (stg == ST_UPD_WALK) attr_walk(b, p);
   endfunction

   function automatic rsp_type body_verdict();
      int unsigned d;
      if (tmis) d = (kind == KIND_OPEN) ? DT_OPT_LEN : DT_ATTR_WALK;
      else if (pend) d = pend;
      else if (kind == KIND_OPEN && !saw_v6) d = DT_NO_V6;
      else return mk((kind == KIND_OPEN && saw_as4) ? STS_VALID_AS4 : STS_VALID, 0, 0,
                     DT_NONE);
      return mk(STS_INVALID, err_tab[d], sub_tab[d], 5'(d));
   endfunction

   function automatic bit header_verdict(int unsigned b, output rsp_type o);
      kind = b;
      if (b == KIND_NOTIFY) begin
         o = mk(STS_NOTIFY, 0, 0, DT_NOTE_SHORT);
         return mlen < 21;
      end
      o = mk(STS_VALID, 0, 0, DT_NONE);
      if (!mgood) o = mk(STS_INVALID, 1, 1, DT_MARKER);
      else if (b == 0 || b > 4) o = mk(STS_INVALID, 1, 3, DT_TYPE);
      else if (mlen < 19 || mlen > MSG_MAX || (b == KIND_OPEN && mlen < 29) ||
               (b == KIND_UPDATE && mlen < 23) || (b == KIND_KEEP && mlen != 19))
         o = mk(STS_INVALID, 1, 2, DT_LENGTH);
      else return mlen == 19;
      return 1;
   endfunction

   function automatic bit message_byte(int unsigned b, int unsigned p, output rsp_type o);
      o = mk(STS_INCOMPLETE, 0, 0, DT_NONE);
      if (p < 16) begin
         if (b != 8'hFF) mgood = 0;
         return 0;
      end
      if (p == 16) begin
         mlen = b << 8;
         return 0;
      end
      if (p == 17) begin
         mlen |= b;
         return 0;
      end
      if (p == 18) return header_verdict(b, o);
      if (kind == KIND_NOTIFY) begin
         if (p == 19) fval = b;
         else if (p == 20) begin
            o = mk(STS_NOTIFY, 8'(fval), 8'(b), DT_NONE);
            return 1;
         end
         return 0;
      end
      if (kind == KIND_OPEN) open_byte(b, p);
      else if (kind == KIND_UPDATE) update_byte(b, p);
      if (p + 1 == mlen) begin
         o = body_verdict();
         return 1;
      end
      return 0;
   endfunction

   function automatic bit verdict_of(req_type r, output rsp_type o);
      int unsigned p;
      bit hit;
      o = mk(STS_INCOMPLETE, 0, 0, DT_NONE);
      if (r.first_byte) clear_msg();
      else if (vgiven) return 0;
      p = pos;
      pos = (p + 1) & 16'hFFFF;
      hit = message_byte(r.data_byte, p, o);
      if (!hit && r.last_byte) begin
         o = mk(STS_INCOMPLETE, 0, 0, DT_NONE);
         hit = 1;
      end
      if (hit) vgiven = 1;
      return hit;
   endfunction

   // message builders
   function automatic void put(int v);
      pkt.push_back(v[7:0]);
   endfunction

   function automatic void put16(int v);
      put(v >> 8); put(v);
   endfunction

   function automatic void patch16(int at, int v);
      pkt[at] = 8'(v >> 8); pkt[at + 1] = 8'(v);
   endfunction

   function automatic void start_hdr(logic [7:0] k);
      pkt.delete();
      repeat (16) put(8'hFF);
      put16(0); put(k);
   endfunction

   function automatic void seal_len();
      patch16(16, pkt.size());
   endfunction

   function automatic void open_head(int ver, int hold);
      start_hdr(KIND_OPEN);
      put(ver); put16($urandom_range(65535)); put16(hold); put16($urandom); put16($urandom);
      put(0);
   endfunction

   function automatic void seal_open();
      pkt[28] = 8'(pkt.size() - 29);
      seal_len();
   endfunction

   function automatic int open_elem(int code);
      put(code); put(0);
      return pkt.size() - 2;
   endfunction

   function automatic void close_elem(int at);
      pkt[at + 1] = 8'(pkt.size() - at - 2);
   endfunction

   function automatic void cap_v6(int afi, int safi);
      int at;
      at = open_elem(1); put16(afi); put(0); put(safi); close_elem(at);
   endfunction

   function automatic void cap_as4();
      int at;
      at = open_elem(65); put16($urandom); put16($urandom); close_elem(at);
   endfunction

   function automatic void good_caps_param(bit as4);
      int at;
      at = open_elem(2); cap_v6(2, 1);
      if (as4) cap_as4();
      close_elem(at);
   endfunction

   function automatic void update_head();
      start_hdr(KIND_UPDATE);
      put16(0);
   endfunction

   function automatic int attrs_open();
      put16(0);
      return pkt.size() - 2;
   endfunction

   function automatic void attrs_close(int at);
      patch16(at, pkt.size() - at - 2);
   endfunction

   function automatic int attr_open(int flags, int code);
      put(flags); put(code);
      if (flags & 8'h10) put16(0);
      else put(0);
      return pkt.size();
   endfunction

   function automatic void attr_close(int at, int flags);
      int n;
      n = pkt.size() - at;
      if (flags & 8'h10) patch16(at - 2, n);
      else pkt[at - 1] = 8'(n);
   endfunction

   function automatic void prefixes(int n);
      int len;
      repeat (n) begin
         len = ($urandom_range(9) == 0) ? $urandom_range(255) : $urandom_range(128);
         put(len);
         repeat ((len + 7) / 8) put($urandom);
      end
   endfunction

   function automatic void attr_mp(bit reach, int nh);
      int at;
      at = attr_open(8'h80, reach ? 14 : 15);
      put16(2); put(1);
      if (reach) begin
         put(nh);
         repeat (nh) put($urandom);
         put(0);
      end
      prefixes($urandom_range(3));
      attr_close(at, 8'h80);
   endfunction

   function automatic void rand_open();
      int nparams, ncaps, at, code;
      open_head(($urandom_range(19) == 0) ? $urandom_range(255) : 4,
                ($urandom_range(9) == 0) ? $urandom_range(4) : $urandom_range(65535));
      nparams = $urandom_range(3);
      for (int i = 0; i < nparams; i++) begin
         at = open_elem(($urandom_range(9) == 0) ? $urandom_range(255) : 2);
         ncaps = $urandom_range(3);
         for (int c = 0; c < ncaps; c++) begin
            case ($urandom_range(5))
               0, 1: cap_v6(($urandom_range(4) == 0) ? 1 : 2,
                            ($urandom_range(4) == 0) ? 2 : 1);
               2: cap_as4();
               default: begin
                  code = ($urandom_range(3) == 0) ? 65 : $urandom_range(255);
                  code = open_elem(code);
                  repeat ($urandom_range(6)) put($urandom);
                  close_elem(code);
               end
            endcase
         end
         close_elem(at);
      end
      if ($urandom_range(3) != 0) good_caps_param(1'($urandom_range(1)));
      seal_open();
   endfunction

   function automatic void rand_update();
      int at, a, flags;
      update_head();
      repeat ($urandom_range(6)) put($urandom);
      patch16(19, pkt.size() - 21);
      at = attrs_open();
      repeat ($urandom_range(4)) begin
         case ($urandom_range(5))
            0: begin
               a = attr_open(8'h40, 1); put($urandom_range(2)); attr_close(a, 8'h40);
            end
            1: begin
               a = attr_open(8'h40, 2);
               repeat ($urandom_range(10)) put($urandom);
               attr_close(a, 8'h40);
            end
            2: attr_mp(1, ($urandom_range(7) == 0) ? $urandom_range(40) :
                          ($urandom_range(1) ? 16 : 32));
            3: attr_mp(0, 0);
            default: begin
               flags = $urandom & 8'hF0;
               a = attr_open(flags, $urandom);
               repeat ($urandom_range(8)) put($urandom);
               attr_close(a, flags);
            end
         endcase
      end
      attrs_close(at);
      repeat ($urandom_range(5)) put($urandom);
      seal_len();
   endfunction

   // driving and checking
   task automatic send_beat(req_type r);
      rsp_type o;
      @(negedge clock);
      while (idle_on && $urandom_range(99) < 23) begin
         req_valid <= 1'b0;
         idle_beats++;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      bytes_sent++;
      if (verdict_of(r, o)) begin
         verdicts.push_back(o);
         verdicts_made++;
         last_pred = o;
         pred_seen = 1;
      end
   endtask

   task automatic send_pkt(int upto, bit mark_last, int stray_last);
      req_type r;
      for (int i = 0; i < upto; i++) begin
         r.data_byte = pkt[i];
         r.first_byte = (i == 0);
         r.last_byte = (mark_last && i == upto - 1) || i == stray_last;
         send_beat(r);
      end
   endtask

   task automatic report(string what, int got, int want);
      $display("mismatch %0s: got %0d, want %0d (verdict %0d)", what, got, want,
               verdicts_seen);
      errors++;
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (verdicts.size() == 0) report("unexpected verdict, status", rsp_payload.status, -1);
         else begin
            if (rsp_payload.status !== verdicts[0].status)
               report("status", rsp_payload.status, verdicts[0].status);
            if (rsp_payload.error_code !== verdicts[0].error_code)
               report("error_code", rsp_payload.error_code, verdicts[0].error_code);
            if (rsp_payload.suberror_code !== verdicts[0].suberror_code)
               report("suberror_code", rsp_payload.suberror_code, verdicts[0].suberror_code);
            if (rsp_payload.detail !== verdicts[0].detail)
               report("detail", rsp_payload.detail, verdicts[0].detail);
            status_cnt[verdicts[0].status]++;
            void'(verdicts.pop_front());
         end
         verdicts_seen++;
      end
   end

   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left--;
      end else rsp_stall <= idle_on && ($urandom_range(99) < 23);
   end

   int quiet;
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet = 0;
      else quiet++;
      if (quiet >= STALL_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   typedef enum int {
      D_KEEP, D_BAD_MARKER, D_TYPE0, D_TYPE5, D_KEEP_LEN20, D_NOTE_SHORT, D_NOTE,
      D_OPEN_AS4, D_OPEN_V6, D_OPEN_VER, D_OPEN_HOLD, D_OPEN_NOCAP, D_OPEN_PTYPE,
      D_OPEN_OPTLEN, D_UPD_EMPTY, D_UPD_WLEN, D_UPD_ASPATH, D_UPD_NH, D_UPD_MPSHORT,
      D_UPD_WALK, D_UPD_MP, D_UPD_BIG, D_LEN_BIG, D_TRUNC, D_ABANDON
   } case_sel;

   typedef struct {
      case_sel sel;
      bit      typed;
      rsp_type want;
   } case_row;

   case_row plan [] = '{
      '{D_KEEP,        1, '{STS_VALID,      0, 0,  DT_NONE}},
      '{D_BAD_MARKER,  1, '{STS_INVALID,    1, 1,  DT_MARKER}},
      '{D_TYPE0,       1, '{STS_INVALID,    1, 3,  DT_TYPE}},
      '{D_TYPE5,       1, '{STS_INVALID,    1, 3,  DT_TYPE}},
      '{D_KEEP_LEN20,  1, '{STS_INVALID,    1, 2,  DT_LENGTH}},
      '{D_NOTE_SHORT,  1, '{STS_NOTIFY,     0, 0,  DT_NOTE_SHORT}},
      '{D_NOTE,        1, '{STS_NOTIFY,     6, 2,  DT_NONE}},
      '{D_OPEN_AS4,    1, '{STS_VALID_AS4,  0, 0,  DT_NONE}},
      '{D_OPEN_V6,     1, '{STS_VALID,      0, 0,  DT_NONE}},
      '{D_OPEN_VER,    1, '{STS_INVALID,    2, 1,  DT_VERSION}},
      '{D_OPEN_HOLD,   1, '{STS_INVALID,    2, 6,  DT_HOLD}},
      '{D_OPEN_NOCAP,  1, '{STS_INVALID,    2, 0,  DT_NO_V6}},
      '{D_OPEN_PTYPE,  1, '{STS_INVALID,    2, 4,  DT_OPT_PARAM}},
      '{D_OPEN_OPTLEN, 1, '{STS_INVALID,    2, 0,  DT_OPT_LEN}},
      '{D_UPD_EMPTY,   1, '{STS_VALID,      0, 0,  DT_NONE}},
      '{D_UPD_WLEN,    1, '{STS_INVALID,    3, 0,  DT_UPD_LEN}},
      '{D_UPD_ASPATH,  1, '{STS_INVALID,    3, 11, DT_AS_PATH}},
      '{D_UPD_NH,      1, '{STS_INVALID,    3, 0,  DT_NEXT_HOP}},
      '{D_UPD_MPSHORT, 1, '{STS_INVALID,    3, 0,  DT_MP_NLRI}},
      '{D_UPD_WALK,    1, '{STS_INVALID,    3, 1,  DT_ATTR_WALK}},
      '{D_UPD_MP,      0, '{STS_VALID,      0, 0,  DT_NONE}},
      '{D_UPD_BIG,     1, '{STS_VALID,      0, 0,  DT_NONE}},
      '{D_LEN_BIG,     1, '{STS_INVALID,    1, 2,  DT_LENGTH}},
      '{D_TRUNC,       1, '{STS_INCOMPLETE, 0, 0,  DT_NONE}},
      '{D_ABANDON,     0, '{STS_VALID,      0, 0,  DT_NONE}}
   };

   task automatic build_case(case_sel sel, output int upto, output bit mark_last);
      int at, a;
      upto = -1;
      mark_last = 0;
      case (sel)
         D_KEEP, D_BAD_MARKER: begin
            start_hdr(KIND_KEEP); seal_len();
            if (sel == D_BAD_MARKER) pkt[5] = 8'h00;
         end
         D_TYPE0: begin start_hdr(0); seal_len(); end
         D_TYPE5: begin start_hdr(5); seal_len(); end
         D_KEEP_LEN20: begin start_hdr(KIND_KEEP); put(8'hFF); seal_len(); end
         D_NOTE_SHORT: begin start_hdr(KIND_NOTIFY); seal_len(); end
         D_NOTE: begin start_hdr(KIND_NOTIFY); put(6); put(2); seal_len(); end
         D_OPEN_AS4, D_OPEN_V6, D_OPEN_OPTLEN, D_TRUNC, D_ABANDON: begin
            open_head(4, 180); good_caps_param(sel == D_OPEN_AS4); seal_open();
            if (sel == D_OPEN_OPTLEN) pkt[28] = pkt[28] + 8'd1;
            if (sel == D_TRUNC) begin upto = 25; mark_last = 1; end
            if (sel == D_ABANDON) upto = 33;
         end
         D_OPEN_VER: begin open_head(3, 90); good_caps_param(0); seal_open(); end
         D_OPEN_HOLD: begin open_head(4, 1); good_caps_param(0); seal_open(); end
         D_OPEN_NOCAP: begin open_head(4, 65535); seal_open(); end
         D_OPEN_PTYPE: begin
            open_head(4, 3);
            at = open_elem(1); put(8'h00); close_elem(at);
            good_caps_param(0); seal_open();
         end
         D_UPD_WLEN: begin update_head(); patch16(19, 200); put16(0); seal_len(); end
         default: begin
            update_head();
            at = attrs_open();
            case (sel)
               D_UPD_ASPATH: begin a = attr_open(8'h40, 2); put(2); attr_close(a, 8'h40); end
               D_UPD_NH: attr_mp(1, 8);
               D_UPD_MPSHORT: begin
                  a = attr_open(8'h80, 15); put16(2); attr_close(a, 8'h80);
               end
               D_UPD_WALK: begin
                  a = attr_open(8'h40, 1); put(0); attr_close(a, 8'h40); put(0);
               end
               D_UPD_MP: begin attr_mp(1, 32); attr_mp(0, 0); end
               D_UPD_BIG: begin
                  a = attr_open(8'h10, 99);
                  repeat (300) put($urandom);
                  attr_close(a, 8'h10);
               end
               default: ;
            endcase
            attrs_close(at);
            seal_len();
            if (sel == D_LEN_BIG) patch16(16, 16'hFFFF);
         end
      endcase
      if (upto < 0) upto = pkt.size();
   endtask

   initial begin
      int      upto, msgs, pick, cut;
      bit      mark_last;
      req_type r;
      reset = 1'b1;
      req_valid = 1'b0;
      req_payload = '0;
      hold_left = 0;
      idle_on = 1;
      errors = 0; bytes_sent = 0; verdicts_made = 0; idle_beats = 0;
      clear_msg();
      vgiven = 1;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (plan[i]) begin
         build_case(plan[i].sel, upto, mark_last);
         pred_seen = 0;
         send_pkt(upto, mark_last, -1);
         if (plan[i].typed && (!pred_seen || last_pred != plan[i].want))
            report("directed row verdict", last_pred.detail, plan[i].want.detail);
      end

      // stall the result side while keepalives keep arriving
      hold_left = 400;
      repeat (12) begin
         start_hdr(KIND_KEEP); seal_len();
         send_pkt(pkt.size(), 0, -1);
      end
      @(negedge clock);
      req_valid <= 1'b0;
      wait (verdicts.size() == 0);
      repeat (4) @(posedge clock);

      msgs = 0;
      while (bytes_sent < RANDOM_BYTES || verdicts_made < RANDOM_VERDICTS) begin
         idle_on = !(msgs >= 4 && msgs < 12);
         pick = $urandom_range(99);
         if (pick < 40) rand_open();
         else if (pick < 80) rand_update();
         else if (pick < 90) begin start_hdr(KIND_KEEP); seal_len(); end
         else begin
            start_hdr(($urandom_range(4) == 0) ? 8'($urandom) : KIND_NOTIFY);
            repeat ($urandom_range(4)) put($urandom);
            seal_len();
         end
         upto = pkt.size();
         mark_last = 1'($urandom_range(1));
         cut = -1;
         case ($urandom_range(9))
            0: pkt[$urandom_range(upto - 1)] = 8'($urandom);
            1: begin upto = $urandom_range(upto, 1); mark_last = 1; end
            2: begin upto = $urandom_range(upto, 1); mark_last = 0; end
            3: cut = $urandom_range(upto - 1);
            default: ;
         endcase
         send_pkt(upto, mark_last, cut);
         if ($urandom_range(7) == 0) begin
            repeat ($urandom_range(3)) begin
               r.data_byte = 8'($urandom);
               r.first_byte = 1'b0;
               r.last_byte = 1'($urandom_range(1));
               send_beat(r);
            end
         end
         msgs++;
      end

      @(negedge clock);
      req_valid <= 1'b0;
      wait (verdicts.size() == 0);
      repeat (10) @(posedge clock);
      $display("covered %0d bytes in %0d verdicts: valid %0d, 32-bit ASN %0d, invalid %0d,",
               bytes_sent, verdicts_seen, status_cnt[STS_VALID], status_cnt[STS_VALID_AS4],
               status_cnt[STS_INVALID]);
      $display("incomplete %0d, notification %0d; %0d sender gaps", status_cnt[STS_INCOMPLETE],
               status_cnt[STS_NOTIFY], idle_beats);
      if (errors == 0) $display("TB_OK");
      else $display("TB_ERROR");
      $finish;
   end

endmodule
